[rtl/vbsu_pkg.sv]
// Shared types and constants for the voice bank bulk-dump unpacker.
package vbsu_pkg;

  localparam int NUM_VOICES    = 32;
  localparam int VOICE_BYTES   = 128;
  localparam int NUM_OPERATORS = 6;
  localparam int OP_BYTES      = 17;
  localparam int GLOBAL_BYTES  = 16;
  localparam int HEADER_BYTES  = 6;

  localparam int POS_W   = 13;
  localparam int VOICE_W = 5;
  localparam int OFFS_W  = 7;

  localparam logic [POS_W-1:0] POS_MAX   = 13'h1fff;
  localparam logic [POS_W-1:0] POS_HDR   = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_CSUM  = POS_W'(HEADER_BYTES + NUM_VOICES * VOICE_BYTES);
  localparam logic [POS_W-1:0] POS_EOX   = POS_W'(HEADER_BYTES + NUM_VOICES * VOICE_BYTES + 1);

  localparam logic [7:0] SYX_START  = 8'hf0;
  localparam logic [7:0] SYX_MAKER  = 8'h43;
  localparam logic [7:0] SYX_FORMAT = 8'h09;
  localparam logic [7:0] SYX_CNT_HI = 8'h20;
  localparam logic [7:0] SYX_CNT_LO = 8'h00;
  localparam logic [7:0] SYX_END    = 8'hf7;

  // byte offsets inside one voice
  localparam logic [OFFS_W-1:0] OFFS_GLOBAL = OFFS_W'(NUM_OPERATORS * OP_BYTES);
  localparam logic [OFFS_W-1:0] OFFS_NAME   = OFFS_W'(NUM_OPERATORS * OP_BYTES + GLOBAL_BYTES);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [3:0] {
    ST_PARAM    = 4'd0,
    ST_ACCEPTED = 4'd1,
    ST_ERR_START = 4'd2,
    ST_ERR_MAKER = 4'd3,
    ST_ERR_FORMAT = 4'd4,
    ST_ERR_COUNT = 4'd5,
    ST_ERR_CSUM = 4'd6,
    ST_ERR_END  = 4'd7,
    ST_ERR_LEN  = 4'd8
  } status_t;

  // One queue entry: either a data byte to unpack or a single status report.
  typedef struct packed {
    status_t              status;
    logic [VOICE_W-1:0]   voice;
    logic [OFFS_W-1:0]    offs;
    logic [7:0]           data;
  } qent_t;

endpackage

[rtl/vbsu_front.sv]
// Front end: header, checksum, end-byte and length checks; queues bytes and status reports.
module vbsu_front
  import vbsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_take,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       push,
  output qent_t      push_ent
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [6:0]       sum_r, sum_nxt;
  logic [7:0]       cnt_hi_r, cnt_hi_nxt;
  logic             err_r, err_nxt;
  status_t          err;
  logic [POS_W-1:0] rel;

  assign rel = pos_r - POS_HDR;

  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    cnt_hi_nxt = cnt_hi_r;
    err_nxt    = err_r;
    err        = ST_PARAM;
    push       = 1'b0;
    push_ent.status = ST_PARAM;
    push_ent.voice  = rel[OFFS_W +: VOICE_W];
    push_ent.offs   = rel[OFFS_W-1:0];
    push_ent.data   = in_byte;
    if (in_take && !err_r) begin
      if (pos_r == 13'd0) begin
        if (in_byte != SYX_START) err = ST_ERR_START;
      end else if (pos_r == 13'd1) begin
        if (in_byte != SYX_MAKER) err = ST_ERR_MAKER;
      end else if (pos_r == 13'd3) begin
        if (in_byte != SYX_FORMAT) err = ST_ERR_FORMAT;
      end else if (pos_r == 13'd4) begin
        cnt_hi_nxt = in_byte;
      end else if (pos_r == 13'd5) begin
        if (cnt_hi_r != SYX_CNT_HI || in_byte != SYX_CNT_LO) err = ST_ERR_COUNT;
      end else if (pos_r >= POS_HDR && pos_r < POS_CSUM) begin
        sum_nxt = sum_r - in_byte[6:0];
        if (!in_end) push = 1'b1;
      end else if (pos_r == POS_CSUM) begin
        if (in_byte != {1'b0, sum_r}) err = ST_ERR_CSUM;
      end else if (pos_r == POS_EOX) begin
        if (in_byte != SYX_END) err = ST_ERR_END;
        else if (!in_end) err = ST_ERR_LEN;
        else begin
          push = 1'b1;
          push_ent.status = ST_ACCEPTED;
        end
      end else if (pos_r > POS_EOX) begin
        err = ST_ERR_LEN;
      end
      if (err == ST_PARAM && in_end && pos_r < POS_EOX) err = ST_ERR_LEN;
      if (err != ST_PARAM) begin
        push            = 1'b1;
        push_ent.status = err;
        err_nxt         = 1'b1;
      end
      if (!err_nxt && pos_r < POS_MAX) pos_nxt = pos_r + 13'd1;
    end
    // end of message clears everything, latched error or not
    if (in_take && in_end) begin
      pos_nxt    = '0;
      sum_nxt    = '0;
      cnt_hi_nxt = '0;
      err_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      cnt_hi_r <= '0;
      err_r    <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      cnt_hi_r <= cnt_hi_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

[rtl/vbsu_fifo.sv]
// Short queue of classified bytes between the front and back ends.
module vbsu_fifo
  import vbsu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output qent_t head
);

  qent_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/vbsu_back.sv]
// Back end: splits queued bytes into results, one per cycle when not stalled.
module vbsu_back
  import vbsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        empty,
  input  qent_t       head,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tlast
);

  logic [1:0]         sub_r, sub_nxt;
  logic               vld_r, vld_nxt;
  logic [VOICE_W-1:0] voice_r;
  logic [2:0]         opn_r;
  logic [4:0]         id_r;
  logic [6:0]         val_r;
  status_t            stat_r;
  logic               last_r;

  logic [1:0]  cnt;
  logic [2:0]  opn, opidx;
  logic [4:0]  id;
  logic [6:0]  val;
  logic [6:0]  o, base, fo, go, co;
  logic [4:0]  f;
  logic [3:0]  g;
  logic [7:0]  b;
  logic        load;

  // offset-in-voice to operator index: compare chain instead of a divide by 17
  always_comb begin
    o = head.offs;
    b = head.data;
    if (o >= 7'd85)      opidx = 3'd5;
    else if (o >= 7'd68) opidx = 3'd4;
    else if (o >= 7'd51) opidx = 3'd3;
    else if (o >= 7'd34) opidx = 3'd2;
    else if (o >= 7'd17) opidx = 3'd1;
    else                 opidx = 3'd0;
    case (opidx)
      3'd1:    base = 7'd17;
      3'd2:    base = 7'd34;
      3'd3:    base = 7'd51;
      3'd4:    base = 7'd68;
      3'd5:    base = 7'd85;
      default: base = 7'd0;
    endcase
    fo = o - base;
    f  = fo[4:0];
    go = o - OFFS_GLOBAL;
    g  = go[3:0];
    co = o - OFFS_NAME;
  end

  always_comb begin
    cnt = 2'd1;
    opn = 3'd0;
    id  = 5'd0;
    val = 7'd0;
    if (head.status != ST_PARAM) begin
      cnt = 2'd1;
    end else if (o < OFFS_GLOBAL) begin
      opn = 3'(NUM_OPERATORS) - opidx;
      case (f)
        5'd11: begin
          cnt = 2'd2;
          id  = (sub_r == 2'd0) ? 5'd11 : 5'd12;
          val = (sub_r == 2'd0) ? {5'd0, b[1:0]} : {5'd0, b[3:2]};
        end
        5'd12: begin
          cnt = 2'd2;
          id  = (sub_r == 2'd0) ? 5'd13 : 5'd14;
          val = (sub_r == 2'd0) ? {3'd0, b[6:3]} : {4'd0, b[2:0]};
        end
        5'd13: begin
          cnt = 2'd2;
          id  = (sub_r == 2'd0) ? 5'd15 : 5'd16;
          val = (sub_r == 2'd0) ? {4'd0, b[4:2]} : {5'd0, b[1:0]};
        end
        5'd14: begin
          id  = 5'd17;
          val = b[6:0];
        end
        5'd15: begin
          cnt = 2'd2;
          id  = (sub_r == 2'd0) ? 5'd18 : 5'd19;
          val = (sub_r == 2'd0) ? {2'd0, b[5:1]} : {6'd0, b[0]};
        end
        5'd16: begin
          id  = 5'd20;
          val = b[6:0];
        end
        default: begin
          id  = f;
          val = b[6:0];
        end
      endcase
    end else if (o < OFFS_NAME) begin
      case (g)
        4'd9: begin
          cnt = 2'd2;
          id  = (sub_r == 2'd0) ? 5'd9 : 5'd10;
          val = (sub_r == 2'd0) ? {4'd0, b[2:0]} : {6'd0, b[3]};
        end
        4'd10, 4'd11, 4'd12, 4'd13: begin
          id  = {1'b0, g} + 5'd1;
          val = b[6:0];
        end
        4'd14: begin
          cnt = 2'd3;
          case (sub_r)
            2'd0: begin
              id  = 5'd15;
              val = {4'd0, b[6:4]};
            end
            2'd1: begin
              id  = 5'd16;
              val = {4'd0, b[3:1]};
            end
            default: begin
              id  = 5'd17;
              val = {6'd0, b[0]};
            end
          endcase
        end
        4'd15: begin
          id  = 5'd18;
          val = b[6:0];
        end
        default: begin
          id  = {1'b0, g};
          val = b[6:0];
        end
      endcase
    end else begin
      id = 5'd19 + co[4:0];
      // name character cleanup
      if (b < 8'd32 || b > 8'd127) val = 7'd95;
      else if (b == 8'd92)         val = 7'd89;
      else if (b == 8'd126)        val = 7'd60;
      else if (b == 8'd127)        val = 7'd62;
      else                         val = b[6:0];
    end
  end

  assign load = !empty && (!vld_r || out_tready);
  assign pop  = load && (sub_r == cnt - 2'd1);

  always_comb begin
    sub_nxt = sub_r;
    if (pop) sub_nxt = 2'd0;
    else if (load) sub_nxt = sub_r + 2'd1;
    vld_nxt = vld_r;
    if (load) vld_nxt = 1'b1;
    else if (out_tready) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= '0;
      vld_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      voice_r <= (head.status == ST_PARAM) ? head.voice : '0;
      opn_r   <= opn;
      id_r    <= id;
      val_r   <= val;
      stat_r  <= head.status;
      last_r  <= pop;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {stat_r, val_r, id_r, opn_r, voice_r};
  assign out_tlast  = last_r;

  a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> sub_r < cnt)
    else $error("sub-result index past result count");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && stat_r != ST_PARAM |-> last_r && voice_r == '0 && opn_r == '0
      && id_r == '0 && val_r == '0)
    else $error("status result carries payload or is not last");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (last_r == (sub_r == 2'd0)))
    else $error("last flag out of step with sub-result index");

endmodule

[rtl/voice_bank_sysex_unpacker.sv]
// Top level of the 32-voice bulk-dump unpacker.
// Takes a bulk-dump message one byte per transaction on in_* (in_tlast marks
// the host's last byte of the message) and emits parameter and status results
// on out_* (out_tlast marks the last result caused by one byte). The front end
// checks a byte in the cycle it arrives and drops data bytes and status reports
// into a four-entry queue; the back end drains that queue through a single
// output register, one result per cycle while out_tready is high. A byte is
// accepted every cycle while the queue has room. A voice data byte yields three
// results for the packed LFO/mod byte, two for split operator and global bytes
// and one otherwise; header and checksum bytes yield none unless a check fails.
// A full voice is 155 results for 128 bytes.
// After an error, bytes are swallowed with no results until in_tlast.
module voice_bank_sysex_unpacker
  import vbsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // message_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [4:0] voice_number, [7:5] operator_number,
                                  // [12:8] param_id, [19:13] param_value,
                                  // [23:20] status_code
  output logic        out_tlast   // last_of_run
);

  logic  full, empty, push, pop, take;
  qent_t push_ent, head;

  assign in_tready = !full;
  assign take      = in_tvalid && in_tready;

  vbsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (take),
    .in_byte  (in_tdata),
    .in_end   (in_tlast),
    .push     (push),
    .push_ent (push_ent)
  );

  vbsu_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  vbsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/testbench.sv]
// Testbench for the bulk-dump unpacker: directed and random dumps, scoreboard checked.
`timescale 1ns / 100ps

module testbench;
  import vbsu_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BYTES = 310;
  localparam int DRAIN_CYCLES = 20;

  // packed parameter ids
  localparam int PID_CURVE_L    = 11;
  localparam int PID_CURVE_R    = 12;
  localparam int PID_DETUNE     = 13;
  localparam int PID_RATE_SCALE = 14;
  localparam int PID_KEY_VEL    = 15;
  localparam int PID_AMP_MOD    = 16;
  localparam int PID_OUT_LEVEL  = 17;
  localparam int PID_COARSE     = 18;
  localparam int PID_OSC_MODE   = 19;
  localparam int PID_FINE       = 20;
  localparam int PID_FEEDBACK   = 9;
  localparam int PID_OSC_SYNC   = 10;
  localparam int PID_PITCH_MOD  = 15;
  localparam int PID_LFO_WAVE   = 16;
  localparam int PID_LFO_SYNC   = 17;
  localparam int PID_TRANSPOSE  = 18;
  localparam int PID_NAME0      = 19;

  typedef struct {
    logic [4:0] voice;
    logic [2:0] op;
    logic [4:0] id;
    logic [6:0] val;
    status_t    status;
    bit         is_last;
  } vparam_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  // parser shadow state
  logic [POS_W-1:0] parse_pos = '0;
  logic [6:0]       csum = '0;
  logic [7:0]       cnt_hi = '0;
  bit               err_held = 1'b0;

  vparam_t    expected_params[$];
  logic [7:0] frame[$];
  logic [7:0] name_probe [8] = '{8'h00, 8'h1f, 8'h20, 8'h5c, 8'h7e, 8'h7f, 8'h80, 8'hff};

  bit no_idle = 1'b0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int live_bytes = 0;
  int results_checked = 0;
  int dumps_accepted = 0;
  int errors_seen = 0;

  voice_bank_sysex_unpacker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout with %0d results outstanding", expected_params.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  task report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic vparam_t make_param(int vn, int opn, int id, int val, status_t st);
    vparam_t p;
    p.voice = vn[4:0];
    p.op = opn[2:0];
    p.id = id[4:0];
    p.val = val[6:0];
    p.status = st;
    p.is_last = 1'b0;
    return p;
  endfunction

  function automatic logic [7:0] name_char(logic [7:0] b);
    if (b < 8'd32 || b > 8'd127) return "_";
    if (b == "\\") return "Y";
    if (b == "~") return "<";
    if (b == 8'd127) return ">";
    return b;
  endfunction

  task clear_parser();
    parse_pos = '0;
    csum = '0;
    cnt_hi = '0;
    err_held = 1'b0;
  endtask

  // Work out the results one accepted byte causes and queue them.
  task automatic predict_byte(input logic [7:0] b, input bit is_end);
    vparam_t run[$];
    status_t err;
    int rel, vn, o, opn, f, g;
    if (err_held) begin
      if (is_end) clear_parser();
      return;
    end
    live_bytes++;
    err = ST_PARAM;
    if (parse_pos == 0) begin
      if (b != SYX_START) err = ST_ERR_START;
    end else if (parse_pos == 1) begin
      if (b != SYX_MAKER) err = ST_ERR_MAKER;
    end else if (parse_pos == 3) begin
      if (b != SYX_FORMAT) err = ST_ERR_FORMAT;
    end else if (parse_pos == 4) begin
      cnt_hi = b;
    end else if (parse_pos == 5) begin
      if (cnt_hi != SYX_CNT_HI || b != SYX_CNT_LO) err = ST_ERR_COUNT;
    end else if (parse_pos >= POS_HDR && parse_pos < POS_CSUM) begin
      csum = csum - b[6:0];
      if (!is_end) begin
        rel = int'(parse_pos) - HEADER_BYTES;
        vn = rel / VOICE_BYTES;
        o = rel % VOICE_BYTES;
        if (o < OFFS_GLOBAL) begin
          opn = NUM_OPERATORS - o / OP_BYTES;
          f = o % OP_BYTES;
          case (f)
            11: begin
              run = {run, make_param(vn, opn, PID_CURVE_L, b & 8'h03, ST_PARAM)};
              run = {run, make_param(vn, opn, PID_CURVE_R, (b >> 2) & 8'h03, ST_PARAM)};
            end
            12: begin
              run = {run, make_param(vn, opn, PID_DETUNE, (b >> 3) & 8'h0f, ST_PARAM)};
              run = {run, make_param(vn, opn, PID_RATE_SCALE, b & 8'h07, ST_PARAM)};
            end
            13: begin
              run = {run, make_param(vn, opn, PID_KEY_VEL, (b >> 2) & 8'h07, ST_PARAM)};
              run = {run, make_param(vn, opn, PID_AMP_MOD, b & 8'h03, ST_PARAM)};
            end
            14: run = {run, make_param(vn, opn, PID_OUT_LEVEL, b & 8'h7f, ST_PARAM)};
            15: begin
              run = {run, make_param(vn, opn, PID_COARSE, (b >> 1) & 8'h1f, ST_PARAM)};
              run = {run, make_param(vn, opn, PID_OSC_MODE, b & 8'h01, ST_PARAM)};
            end
            16: run = {run, make_param(vn, opn, PID_FINE, b & 8'h7f, ST_PARAM)};
            default: run = {run, make_param(vn, opn, f, b & 8'h7f, ST_PARAM)};
          endcase
        end else if (o < OFFS_NAME) begin
          g = o - OFFS_GLOBAL;
          if (g <= 8) begin
            run = {run, make_param(vn, 0, g, b & 8'h7f, ST_PARAM)};
          end else if (g == 9) begin
            run = {run, make_param(vn, 0, PID_FEEDBACK, b & 8'h07, ST_PARAM)};
            run = {run, make_param(vn, 0, PID_OSC_SYNC, (b >> 3) & 8'h01, ST_PARAM)};
          end else if (g <= 13) begin
            run = {run, make_param(vn, 0, g + 1, b & 8'h7f, ST_PARAM)};
          end else if (g == 14) begin
            // pitch-mod sensitivity, LFO wave and LFO sync share one byte
            run = {run, make_param(vn, 0, PID_PITCH_MOD, (b >> 4) & 8'h07, ST_PARAM)};
            run = {run, make_param(vn, 0, PID_LFO_WAVE, (b >> 1) & 8'h07, ST_PARAM)};
            run = {run, make_param(vn, 0, PID_LFO_SYNC, b & 8'h01, ST_PARAM)};
          end else begin
            run = {run, make_param(vn, 0, PID_TRANSPOSE, b & 8'h7f, ST_PARAM)};
          end
        end else begin
          run = {run, make_param(vn, 0, PID_NAME0 + o - OFFS_NAME, name_char(b), ST_PARAM)};
        end
      end
    end else if (parse_pos == POS_CSUM) begin
      if (b != {1'b0, csum}) err = ST_ERR_CSUM;
    end else if (parse_pos == POS_EOX) begin
      if (b != SYX_END) err = ST_ERR_END;
      else if (!is_end) err = ST_ERR_LEN;
      else run = {run, make_param(0, 0, 0, 0, ST_ACCEPTED)};
    end else if (parse_pos > POS_EOX) begin
      err = ST_ERR_LEN;
    end

    // early end: header and checksum checks win, otherwise a single length error
    if (err == ST_PARAM && is_end && parse_pos < POS_EOX) err = ST_ERR_LEN;
    if (err != ST_PARAM) begin
      run = {};
      run = {run, make_param(0, 0, 0, 0, err)};
      err_held = 1'b1;
    end
    if (run.size() > 0) run[run.size() - 1].is_last = 1'b1;
    expected_params = {expected_params, run};

    if (is_end) clear_parser();
    else if (!err_held && parse_pos < POS_MAX) parse_pos++;
  endtask

  task send_byte(input logic [7:0] b, input bit is_end);
    if (!no_idle) begin
      while ($urandom_range(99) < 25) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= is_end;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    predict_byte(b, is_end);
  endtask

  task send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  // hold off the sender until every queued result has come back
  task wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_params.size() != 0);
  endtask

  task start_frame();
    frame = {};
    frame = {frame, SYX_START};
    frame = {frame, SYX_MAKER};
    frame = {frame, 8'($urandom_range(255))};
    frame = {frame, SYX_FORMAT};
    frame = {frame, SYX_CNT_HI};
    frame = {frame, SYX_CNT_LO};
  endtask

  // full 32-voice dump with random content and a good checksum
  task build_dump();
    logic [6:0] sum;
    logic [7:0] b;
    start_frame();
    sum = '0;
    for (int i = 0; i < NUM_VOICES * VOICE_BYTES; i++) begin
      if (i % VOICE_BYTES >= OFFS_NAME && $urandom_range(1) == 1)
        b = name_probe[$urandom_range(7)];
      else
        b = 8'($urandom_range(255));
      sum = sum - b[6:0];
      frame = {frame, b};
    end
    frame = {frame, {1'b0, sum}};
    frame = {frame, SYX_END};
  endtask

  task test_header_errors();
    frame = {8'h00, SYX_MAKER, 8'h12};
    send_frame();
    frame = {8'h7f};
    send_frame();
    frame = {SYX_START};
    send_frame();
    frame = {SYX_START, 8'h42, 8'h00};
    send_frame();
    frame = {SYX_START, SYX_MAKER, 8'hff, 8'h08, SYX_CNT_HI};
    send_frame();
    frame = {SYX_START, SYX_MAKER, 8'h7f, SYX_FORMAT, 8'h21, SYX_CNT_LO, 8'h05};
    send_frame();
    frame = {SYX_START, SYX_MAKER, 8'h80, SYX_FORMAT, SYX_CNT_HI, 8'h01};
    send_frame();
    // header alone, then header with two data bytes: both end early
    start_frame();
    send_frame();
    start_frame();
    frame = {frame, 8'hff};
    frame = {frame, 8'h55};
    send_frame();
  endtask

  task test_full_dump_accepted();
    wait_drained();
    no_idle = 1'b1;
    build_dump();
    send_frame();
    wait_drained();
    no_idle = 1'b0;
  endtask

  task test_checksum_errors();
    build_dump();
    frame[POS_CSUM] = frame[POS_CSUM] ^ 8'h01;
    send_frame();
    build_dump();
    frame[POS_CSUM] = frame[POS_CSUM] | 8'h80;
    send_frame();
  endtask

  task test_end_errors();
    build_dump();
    frame[POS_EOX] = 8'hf6;
    send_frame();
    // message ends on the checksum byte
    build_dump();
    void'(frame.pop_back());
    send_frame();
    // good end byte not marked last
    build_dump();
    frame = {frame, 8'($urandom_range(255))};
    frame = {frame, SYX_END};
    send_frame();
  endtask

  task test_random_messages();
    int start_count, kind, n, p;
    int hdr_pos [5];
    hdr_pos = '{0, 1, 3, 4, 5};
    start_count = live_bytes;
    while (live_bytes - start_count < RANDOM_BYTES) begin
      kind = $urandom_range(99);
      if ($urandom_range(9) == 0) wait_drained();
      if (kind < 65) begin
        start_frame();
        n = ($urandom_range(9) == 0) ? $urandom_range(128, 200) : $urandom_range(0, 24);
        repeat (n) frame = {frame, 8'($urandom_range(255))};
      end else if (kind < 85) begin
        start_frame();
        p = hdr_pos[$urandom_range(4)];
        frame[p] = frame[p] ^ 8'($urandom_range(1, 255));
        repeat ($urandom_range(4)) frame = {frame, 8'($urandom_range(255))};
      end else begin
        frame = {};
        repeat ($urandom_range(1, 6)) frame = {frame, 8'($urandom_range(255))};
      end
      send_frame();
    end
  endtask

  // result side: random backpressure and the scoreboard compare
  always @(posedge clk) begin
    vparam_t want;
    if (out_tvalid && out_tready) begin
      results_checked++;
      if (expected_params.size() == 0) begin
        report_mismatch($sformatf("result %h last %b with nothing expected",
                                  out_tdata, out_tlast));
      end else begin
        want = expected_params.pop_front();
        if (want.status == ST_ACCEPTED) dumps_accepted++;
        else if (want.status != ST_PARAM) errors_seen++;
        if (out_tdata[4:0] !== want.voice)
          report_mismatch($sformatf("voice got %0d want %0d", out_tdata[4:0], want.voice));
        if (out_tdata[7:5] !== want.op)
          report_mismatch($sformatf("operator got %0d want %0d", out_tdata[7:5], want.op));
        if (out_tdata[12:8] !== want.id)
          report_mismatch($sformatf("param id got %0d want %0d", out_tdata[12:8], want.id));
        if (out_tdata[19:13] !== want.val)
          report_mismatch($sformatf("value got %0d want %0d (v%0d op%0d id%0d)",
                                    out_tdata[19:13], want.val, want.voice, want.op, want.id));
        if (out_tdata[23:20] !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_tdata[23:20], want.status));
        if (out_tlast !== want.is_last)
          report_mismatch($sformatf("tlast got %b want %b", out_tlast, want.is_last));
      end
    end
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= no_idle || ($urandom_range(99) >= 25);
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_header_errors();
    test_full_dump_accepted();
    test_checksum_errors();
    test_end_errors();
    test_random_messages();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_params.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d bytes sent, %0d parsed before an error, %0d results checked",
             bytes_sent, live_bytes, results_checked);
    $display("summary: %0d dumps accepted, %0d error reports over header, checksum, end, length",
             dumps_accepted, errors_seen);
    if (mismatch_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/vbsu_pkg.sv
rtl/vbsu_front.sv
rtl/vbsu_fifo.sv
rtl/vbsu_back.sv
rtl/voice_bank_sysex_unpacker.sv
tb/testbench.sv
